// ----- rtl/c6502_pkg.sv -----
`timescale 1ns / 1ps
package c6502_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_EXEC  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDWAIT,
        ST_FETCH,
        ST_OPND1,
        ST_OPND2,
        ST_PTR1,
        ST_PTR2,
        ST_DATA,
        ST_PULL2,
        ST_PUSH2,
        ST_DONE
    } state_t;

    // Addressing modes
    typedef enum logic [3:0] {
        AM_IMM,
        AM_ZP,
        AM_ZPX,
        AM_ZPY,
        AM_ABS,
        AM_ABX,
        AM_ABY,
        AM_IZX,
        AM_IZY,
        AM_JMP,
        AM_JMPI,
        AM_JSR,
        AM_RTS,
        AM_IMPL,
        AM_BAD
    } amode_t;

    // Register targets
    typedef enum logic [2:0] {
        RG_NONE,
        RG_A,
        RG_X,
        RG_Y,
        RG_ADC,
        RG_SBC
    } rsel_t;

    typedef struct packed {
        amode_t amode;
        rsel_t  rsel;
        logic   store;
    } decode_t;

    localparam logic [15:0] PC_RESET = 16'hFFFC;
    localparam logic [7:0]  SP_RESET = 8'hFF;
    localparam logic [7:0]  STACK_HI = 8'h01;

    localparam int FL_C = 0;
    localparam int FL_Z = 1;
    localparam int FL_I = 2;
    localparam int FL_D = 3;
    localparam int FL_V = 6;
    localparam int FL_N = 7;

    function automatic decode_t decode_op(input logic [7:0] op);
        decode_t d;
        d.amode = AM_BAD;
        d.rsel  = RG_NONE;
        d.store = 1'b0;
        case (op)
            8'hA9: begin d.amode = AM_IMM; d.rsel = RG_A; end
            8'hA2: begin d.amode = AM_IMM; d.rsel = RG_X; end
            8'hA0: begin d.amode = AM_IMM; d.rsel = RG_Y; end
            8'h69: begin d.amode = AM_IMM; d.rsel = RG_ADC; end
            8'hE9: begin d.amode = AM_IMM; d.rsel = RG_SBC; end
            8'h4C: d.amode = AM_JMP;
            8'h6C: d.amode = AM_JMPI;
            8'h20: d.amode = AM_JSR;
            8'h60: d.amode = AM_RTS;
            8'h18, 8'h38, 8'h58, 8'h78, 8'hB8, 8'hD8, 8'hF8: d.amode = AM_IMPL;
            8'hA5: begin d.amode = AM_ZP;  d.rsel = RG_A; end
            8'hA6: begin d.amode = AM_ZP;  d.rsel = RG_X; end
            8'hA4: begin d.amode = AM_ZP;  d.rsel = RG_Y; end
            8'h85: begin d.amode = AM_ZP;  d.rsel = RG_A; d.store = 1'b1; end
            8'h86: begin d.amode = AM_ZP;  d.rsel = RG_X; d.store = 1'b1; end
            8'h84: begin d.amode = AM_ZP;  d.rsel = RG_Y; d.store = 1'b1; end
            8'hB5: begin d.amode = AM_ZPX; d.rsel = RG_A; end
            8'hB4: begin d.amode = AM_ZPX; d.rsel = RG_Y; end
            8'h95: begin d.amode = AM_ZPX; d.rsel = RG_A; d.store = 1'b1; end
            8'h94: begin d.amode = AM_ZPX; d.rsel = RG_Y; d.store = 1'b1; end
            8'hB6: begin d.amode = AM_ZPY; d.rsel = RG_X; end
            8'h96: begin d.amode = AM_ZPY; d.rsel = RG_X; d.store = 1'b1; end
            8'hAD: begin d.amode = AM_ABS; d.rsel = RG_A; end
            8'hAE: begin d.amode = AM_ABS; d.rsel = RG_X; end
            8'hAC: begin d.amode = AM_ABS; d.rsel = RG_Y; end
            8'h8D: begin d.amode = AM_ABS; d.rsel = RG_A; d.store = 1'b1; end
            8'h8E: begin d.amode = AM_ABS; d.rsel = RG_X; d.store = 1'b1; end
            8'h8C: begin d.amode = AM_ABS; d.rsel = RG_Y; d.store = 1'b1; end
            8'hBD: begin d.amode = AM_ABX; d.rsel = RG_A; end
            8'hBC: begin d.amode = AM_ABX; d.rsel = RG_Y; end
            8'h9D: begin d.amode = AM_ABX; d.rsel = RG_A; d.store = 1'b1; end
            8'hB9: begin d.amode = AM_ABY; d.rsel = RG_A; end
            8'hBE: begin d.amode = AM_ABY; d.rsel = RG_X; end
            8'h99: begin d.amode = AM_ABY; d.rsel = RG_A; d.store = 1'b1; end
            8'hA1: begin d.amode = AM_IZX; d.rsel = RG_A; end
            8'h81: begin d.amode = AM_IZX; d.rsel = RG_A; d.store = 1'b1; end
            8'hB1: begin d.amode = AM_IZY; d.rsel = RG_A; end
            8'h91: begin d.amode = AM_IZY; d.rsel = RG_A; d.store = 1'b1; end
            default: d.amode = AM_BAD;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/c6502_mem.sv -----
`timescale 1ns / 1ps
module c6502_mem #(
    parameter int MEM_DEPTH = 65536
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(MEM_DEPTH)-1:0] addr,
    input  logic [7:0]                   wdata,
    output logic [7:0]                   rdata
);
    logic [7:0] mem_array [MEM_DEPTH];

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[addr] <= wdata;
        end
        rdata <= mem_array[addr];
    end
endmodule

// ----- rtl/cpu_6502_subset_core_unit.sv -----
`timescale 1ns / 1ps
// Channel | Dir | tdata fields, low bit up
// s_axis  | in  | operation[1:0], mem_address[17:2], mem_data[25:18], zero pad to 32
// m_axis  | out | status[0], read_data[8:1], prog_counter[24:9], accumulator[32:25],
//         |     | index_x[40:33], index_y[48:41], stack_pointer[56:49], status_flags[64:57],
//         |     | zero pad to 72
// Write and read beats and instructions are sequenced over accesses of the
// single-port memory (fetch, operand, pointer, data, stack).
// After reset a clearing pass zeroes every address of the memory, with no beat taken.
// The result is held in an output register until taken; no new beat enters until then.
module cpu_6502_subset_core_unit #(
    parameter int MEM_DEPTH = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // operation, mem_address, mem_data
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // status, read_data, prog_counter, accumulator,
                                        // index_x, index_y, stack_pointer, status_flags
);
    import c6502_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);

    state_t      state_reg, state_next;
    logic [AW:0] clr_reg, clr_next;
    logic [15:0] pc_reg, pc_next;
    logic [7:0]  a_reg, a_next, x_reg, x_next, y_reg, y_next, sp_reg, sp_next;
    logic [7:0]  p_reg, p_next;
    logic [7:0]  op_reg, op_next, lo_reg, lo_next;
    logic [15:0] ea_reg, ea_next;
    logic [1:0]  oper_reg, oper_next;
    logic [7:0]  rd_reg, rd_next;
    logic        st_reg, st_next;
    logic        ov_reg, ov_next;

    logic        mem_we;
    logic [15:0] mem_a16;
    logic [7:0]  mem_wd, mem_rd;
    decode_t     dec;
    decode_t     fdec;
    logic [8:0]  sum;
    logic [7:0]  opnd, sres;
    logic [15:0] ret_pc;

    c6502_mem #(.MEM_DEPTH(MEM_DEPTH)) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .addr (mem_a16[AW-1:0]),
        .wdata(mem_wd),
        .rdata(mem_rd)
    );

    assign dec = decode_op(op_reg);
    assign fdec = decode_op(mem_rd);
    assign s_axis_tready = (state_reg == ST_IDLE) && !ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = {7'd0, p_reg, sp_reg, y_reg, x_reg, a_reg, pc_reg, rd_reg, st_reg};

    // Hold state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pc_reg    <= PC_RESET;
            a_reg     <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            sp_reg    <= SP_RESET;
            p_reg     <= '0;
            ov_reg    <= 1'b0;
            st_reg    <= 1'b0;
            rd_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pc_reg    <= pc_next;
            a_reg     <= a_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            sp_reg    <= sp_next;
            p_reg     <= p_next;
            ov_reg    <= ov_next;
            st_reg    <= st_next;
            rd_reg    <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        lo_reg   <= lo_next;
        ea_reg   <= ea_next;
        oper_reg <= oper_next;
    end

    // Sequence memory accesses and update registers
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        pc_next    = pc_reg;
        a_next     = a_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        sp_next    = sp_reg;
        p_next     = p_reg;
        op_next    = op_reg;
        lo_next    = lo_reg;
        ea_next    = ea_reg;
        oper_next  = oper_reg;
        rd_next    = rd_reg;
        st_next    = st_reg;
        ov_next    = ov_reg;
        mem_we     = 1'b0;
        mem_a16    = pc_reg;
        mem_wd     = '0;
        opnd       = (dec.rsel == RG_SBC) ? ~mem_rd : mem_rd;
        sum        = {1'b0, a_reg} + {1'b0, opnd} + {8'd0, p_reg[FL_C]};
        sres       = sum[7:0];
        ret_pc     = pc_reg - 16'd1;

        if (ov_reg && m_axis_tready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_a16  = 16'(clr_reg[AW-1:0]);
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(MEM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid && !ov_reg)
                begin
                    oper_next = s_axis_tdata[1:0];
                    st_next   = 1'b0;
                    rd_next   = '0;
                    mem_a16   = s_axis_tdata[17:2];
                    case (op_t'(s_axis_tdata[1:0]))
                        OP_WRITE:
                        begin
                            mem_we     = 1'b1;
                            mem_wd     = s_axis_tdata[25:18];
                            state_next = ST_DONE;
                        end
                        OP_READ: state_next = ST_RDWAIT;
                        OP_EXEC:
                        begin
                            mem_a16    = pc_reg;
                            pc_next    = pc_reg + 16'd1;
                            state_next = ST_FETCH;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_RDWAIT:
            begin
                rd_next    = mem_rd;
                state_next = ST_DONE;
            end
            ST_FETCH:
            begin
                op_next = mem_rd;
                case (fdec.amode)
                    AM_BAD:
                    begin
                        st_next    = 1'b1;
                        state_next = ST_DONE;
                    end
                    AM_IMPL:
                    begin
                        case (mem_rd)
                            8'h18: p_next[FL_C] = 1'b0;
                            8'h38: p_next[FL_C] = 1'b1;
                            8'h58: p_next[FL_I] = 1'b0;
                            8'h78: p_next[FL_I] = 1'b1;
                            8'hB8: p_next[FL_V] = 1'b0;
                            8'hD8: p_next[FL_D] = 1'b0;
                            default: p_next[FL_D] = 1'b1;
                        endcase
                        state_next = ST_DONE;
                    end
                    AM_RTS:
                    begin
                        mem_a16    = {STACK_HI, sp_reg + 8'd1};
                        sp_next    = sp_reg + 8'd2;
                        state_next = ST_PULL2;
                    end
                    default:
                    begin
                        pc_next    = pc_reg + 16'd1;
                        state_next = ST_OPND1;
                    end
                endcase
            end
            ST_PULL2:
            begin
                lo_next    = mem_rd;
                mem_a16    = {STACK_HI, sp_reg};
                state_next = ST_PTR2;
            end
            ST_OPND1:
            begin
                lo_next = mem_rd;
                case (dec.amode)
                    AM_IMM:
                    begin
                        case (dec.rsel)
                            RG_A: a_next = mem_rd;
                            RG_X: x_next = mem_rd;
                            RG_Y: y_next = mem_rd;
                            default:
                            begin
                                a_next       = sres;
                                p_next[FL_C] = sum[8];
                                p_next[FL_V] = ((a_reg ^ sres) & ~(a_reg ^ opnd)) >> 7 != 8'd0;
                            end
                        endcase
                        if (dec.rsel == RG_A || dec.rsel == RG_X || dec.rsel == RG_Y)
                        begin
                            p_next[FL_N] = mem_rd[7];
                            p_next[FL_Z] = (mem_rd == 8'd0);
                        end
                        else
                        begin
                            p_next[FL_N] = sres[7];
                            p_next[FL_Z] = (sres == 8'd0);
                        end
                        state_next = ST_DONE;
                    end
                    AM_ZP, AM_ZPX, AM_ZPY:
                    begin
                        ea_next = {8'd0, mem_rd
                                   + ((dec.amode == AM_ZPX) ? x_reg :
                                      (dec.amode == AM_ZPY) ? y_reg : 8'd0)};
                        state_next = ST_DATA;
                    end
                    AM_IZX, AM_IZY:
                    begin
                        ea_next    = {8'd0, mem_rd + ((dec.amode == AM_IZX) ? x_reg : 8'd0)};
                        mem_a16    = ea_next;
                        state_next = ST_PTR1;
                    end
                    default:
                    begin
                        pc_next    = pc_reg + 16'd1;
                        state_next = ST_OPND2;
                    end
                endcase
            end
            ST_OPND2:
            begin
                ea_next = {mem_rd, lo_reg};
                case (dec.amode)
                    AM_ABX: ea_next = {mem_rd, lo_reg} + {8'd0, x_reg};
                    AM_ABY: ea_next = {mem_rd, lo_reg} + {8'd0, y_reg};
                    default: ea_next = {mem_rd, lo_reg};
                endcase
                case (dec.amode)
                    AM_JMP:
                    begin
                        pc_next    = {mem_rd, lo_reg};
                        state_next = ST_DONE;
                    end
                    AM_JMPI:
                    begin
                        mem_a16    = ea_next;
                        state_next = ST_PTR1;
                    end
                    AM_JSR:
                    begin
                        mem_we     = 1'b1;
                        mem_a16    = {STACK_HI, sp_reg};
                        mem_wd     = ret_pc[15:8];
                        sp_next    = sp_reg - 8'd1;
                        state_next = ST_PUSH2;
                    end
                    default: state_next = ST_DATA;
                endcase
            end
            ST_PUSH2:
            begin
                mem_we     = 1'b1;
                mem_a16    = {STACK_HI, sp_reg};
                mem_wd     = ret_pc[7:0];
                sp_next    = sp_reg - 8'd1;
                pc_next    = ea_reg;
                state_next = ST_DONE;
            end
            ST_PTR1:
            begin
                lo_next = mem_rd;
                if (dec.amode == AM_JMPI)
                begin
                    mem_a16 = ea_reg + 16'd1;
                end
                else
                begin
                    mem_a16 = {8'd0, ea_reg[7:0] + 8'd1};
                end
                state_next = ST_PTR2;
            end
            ST_PTR2:
            begin
                case (dec.amode)
                    AM_RTS:
                    begin
                        pc_next    = {mem_rd, lo_reg} + 16'd1;
                        state_next = ST_DONE;
                    end
                    AM_JMPI:
                    begin
                        pc_next    = {mem_rd, lo_reg};
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        ea_next = {mem_rd, lo_reg}
                                  + ((dec.amode == AM_IZY) ? {8'd0, y_reg} : 16'd0);
                        state_next = ST_DATA;
                    end
                endcase
            end
            ST_DATA:
            begin
                mem_a16 = ea_reg;
                if (dec.store)
                begin
                    mem_we = 1'b1;
                    case (dec.rsel)
                        RG_X: mem_wd = x_reg;
                        RG_Y: mem_wd = y_reg;
                        default: mem_wd = a_reg;
                    endcase
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_RDWAIT;
                    oper_next  = OP_NONE;
                end
            end
            ST_DONE:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Load result of a memory-operand load
        if (state_reg == ST_RDWAIT && oper_reg == OP_NONE)
        begin
            rd_next = '0;
            case (dec.rsel)
                RG_X: x_next = mem_rd;
                RG_Y: y_next = mem_rd;
                default: a_next = mem_rd;
            endcase
            p_next[FL_N] = mem_rd[7];
            p_next[FL_Z] = (mem_rd == 8'd0);
        end
    end
endmodule

// ----- rtl/c6502_checker.sv -----
`timescale 1ns / 1ps
module c6502_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);
    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // One item at a time
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second beat taken while busy");

    // U and B flags stay clear
    a_ub: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[62:61] == 2'b00)
        else $error("U or B flag set");

    // Read data is zero after a failing status
    a_st: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'd0)
        else $error("read data with illegal status");
endmodule

bind cpu_6502_subset_core_unit c6502_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import c6502_pkg::*;

    localparam int MEM_DEPTH  = 65536;
    localparam int WDOG_LIMIT = 400000;
    localparam int N_RANDOM   = 1330;

    // Opcodes exercised by the stimulus
    localparam logic [7:0] OPC_LDA_IMM = 8'hA9, OPC_LDX_IMM = 8'hA2, OPC_LDY_IMM = 8'hA0;
    localparam logic [7:0] OPC_ADC_IMM = 8'h69, OPC_SBC_IMM = 8'hE9;
    localparam logic [7:0] OPC_JMP_ABS = 8'h4C, OPC_JMP_IND = 8'h6C;
    localparam logic [7:0] OPC_JSR = 8'h20, OPC_RTS = 8'h60;
    localparam logic [7:0] OPC_CLC = 8'h18, OPC_SEC = 8'h38, OPC_CLI = 8'h58, OPC_SEI = 8'h78;
    localparam logic [7:0] OPC_CLV = 8'hB8, OPC_CLD = 8'hD8, OPC_SED = 8'hF8;
    localparam logic [7:0] OPC_LDA_ZP = 8'hA5, OPC_LDX_ZP = 8'hA6, OPC_LDY_ZP = 8'hA4;
    localparam logic [7:0] OPC_STA_ZP = 8'h85, OPC_STX_ZP = 8'h86, OPC_STY_ZP = 8'h84;
    localparam logic [7:0] OPC_LDA_ZPX = 8'hB5, OPC_LDY_ZPX = 8'hB4;
    localparam logic [7:0] OPC_STA_ZPX = 8'h95, OPC_STY_ZPX = 8'h94;
    localparam logic [7:0] OPC_LDX_ZPY = 8'hB6, OPC_STX_ZPY = 8'h96;
    localparam logic [7:0] OPC_LDA_ABS = 8'hAD, OPC_LDX_ABS = 8'hAE, OPC_LDY_ABS = 8'hAC;
    localparam logic [7:0] OPC_STA_ABS = 8'h8D, OPC_STX_ABS = 8'h8E, OPC_STY_ABS = 8'h8C;
    localparam logic [7:0] OPC_LDA_ABX = 8'hBD, OPC_LDY_ABX = 8'hBC, OPC_STA_ABX = 8'h9D;
    localparam logic [7:0] OPC_LDA_ABY = 8'hB9, OPC_LDX_ABY = 8'hBE, OPC_STA_ABY = 8'h99;
    localparam logic [7:0] OPC_LDA_IZX = 8'hA1, OPC_STA_IZX = 8'h81;
    localparam logic [7:0] OPC_LDA_IZY = 8'hB1, OPC_STA_IZY = 8'h91;
    localparam logic [7:0] OPC_ILLEGAL = 8'h02;

    localparam logic [7:0] FLAG_C = 8'h01, FLAG_Z = 8'h02, FLAG_I = 8'h04;
    localparam logic [7:0] FLAG_D = 8'h08, FLAG_V = 8'h40, FLAG_N = 8'h80;

    typedef struct packed {
        logic [7:0]  status_flags;
        logic [7:0]  stack_pointer;
        logic [7:0]  index_y;
        logic [7:0]  index_x;
        logic [7:0]  accumulator;
        logic [15:0] prog_counter;
        logic [7:0]  read_data;
        logic        status;
    } cpu_state_t;

    typedef struct {
        op_t         op;
        logic [15:0] addr;
        logic [7:0]  data;
        bit          has_exp;
        cpu_state_t  exp;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;

    cpu_6502_subset_core_unit #(.MEM_DEPTH(MEM_DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predictor copy of the core
    logic [7:0]  cpu_mem [MEM_DEPTH];
    logic [15:0] cpu_pc;
    logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;

    cpu_state_t  pending_results[$];
    cpu_state_t  directed_checks[$];
    bit          directed_has[$];
    int          fail_count;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic logic [7:0] mem_rd(input logic [15:0] a);
        return cpu_mem[a % MEM_DEPTH];
    endfunction

    function automatic logic [7:0] fetch_byte();
        logic [7:0] b;
        b = mem_rd(cpu_pc);
        cpu_pc = cpu_pc + 16'd1;
        return b;
    endfunction

    function automatic logic [15:0] fetch_word();
        logic [7:0] lo;
        logic [7:0] hi;
        lo = fetch_byte();
        hi = fetch_byte();
        return {hi, lo};
    endfunction

    function automatic logic [15:0] zp_ptr(input logic [7:0] zp);
        logic [7:0] zp1;
        zp1 = zp + 8'd1;
        return {mem_rd({8'h00, zp1}), mem_rd({8'h00, zp})};
    endfunction

    function automatic void upd_nz(input logic [7:0] v);
        cpu_p = cpu_p & ~(FLAG_N | FLAG_Z);
        if (v == 8'd0) cpu_p = cpu_p | FLAG_Z;
        if (v[7]) cpu_p = cpu_p | FLAG_N;
    endfunction

    function automatic void add_acc(input logic [7:0] m);
        logic [8:0] sum;
        sum = {1'b0, cpu_a} + {1'b0, m} + {8'd0, cpu_p[0]};
        cpu_p = cpu_p & ~(FLAG_C | FLAG_V);
        if (sum[8]) cpu_p = cpu_p | FLAG_C;
        if (((cpu_a ^ sum[7:0]) & ~(cpu_a ^ m) & 8'h80) != 8'd0) cpu_p = cpu_p | FLAG_V;
        cpu_a = sum[7:0];
        upd_nz(cpu_a);
    endfunction

    // Execute one instruction; return 1 when the opcode is unknown
    function automatic bit exec_insn();
        logic [7:0]  opc;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [15:0] ea;
        logic [15:0] ret;
        logic [7:0]  val;
        opc = fetch_byte();
        case (opc)
            OPC_LDA_IMM: begin cpu_a = fetch_byte(); upd_nz(cpu_a); return 0; end
            OPC_LDX_IMM: begin cpu_x = fetch_byte(); upd_nz(cpu_x); return 0; end
            OPC_LDY_IMM: begin cpu_y = fetch_byte(); upd_nz(cpu_y); return 0; end
            OPC_ADC_IMM: begin add_acc(fetch_byte()); return 0; end
            OPC_SBC_IMM: begin add_acc(~fetch_byte()); return 0; end
            OPC_JMP_ABS: begin cpu_pc = fetch_word(); return 0; end
            OPC_JMP_IND:
            begin
                ea = fetch_word();
                cpu_pc = {mem_rd(ea + 16'd1), mem_rd(ea)};
                return 0;
            end
            OPC_JSR:
            begin
                ea = fetch_word();
                ret = cpu_pc - 16'd1;
                cpu_mem[{8'h01, cpu_sp} % MEM_DEPTH] = ret[15:8];
                cpu_sp = cpu_sp - 8'd1;
                cpu_mem[{8'h01, cpu_sp} % MEM_DEPTH] = ret[7:0];
                cpu_sp = cpu_sp - 8'd1;
                cpu_pc = ea;
                return 0;
            end
            OPC_RTS:
            begin
                cpu_sp = cpu_sp + 8'd1;
                lo = mem_rd({8'h01, cpu_sp});
                cpu_sp = cpu_sp + 8'd1;
                hi = mem_rd({8'h01, cpu_sp});
                cpu_pc = {hi, lo} + 16'd1;
                return 0;
            end
            OPC_CLC: begin cpu_p = cpu_p & ~FLAG_C; return 0; end
            OPC_SEC: begin cpu_p = cpu_p | FLAG_C; return 0; end
            OPC_CLI: begin cpu_p = cpu_p & ~FLAG_I; return 0; end
            OPC_SEI: begin cpu_p = cpu_p | FLAG_I; return 0; end
            OPC_CLV: begin cpu_p = cpu_p & ~FLAG_V; return 0; end
            OPC_CLD: begin cpu_p = cpu_p & ~FLAG_D; return 0; end
            OPC_SED: begin cpu_p = cpu_p | FLAG_D; return 0; end
            default: ;
        endcase
        // Resolve the effective address of the memory-operand modes
        case (opc)
            OPC_LDA_ZP, OPC_LDX_ZP, OPC_LDY_ZP, OPC_STA_ZP, OPC_STX_ZP, OPC_STY_ZP:
                ea = {8'h00, fetch_byte()};
            OPC_LDA_ZPX, OPC_LDY_ZPX, OPC_STA_ZPX, OPC_STY_ZPX:
                ea = {8'h00, fetch_byte() + cpu_x};
            OPC_LDX_ZPY, OPC_STX_ZPY:
                ea = {8'h00, fetch_byte() + cpu_y};
            OPC_LDA_ABS, OPC_LDX_ABS, OPC_LDY_ABS, OPC_STA_ABS, OPC_STX_ABS, OPC_STY_ABS:
                ea = fetch_word();
            OPC_LDA_ABX, OPC_LDY_ABX, OPC_STA_ABX:
                ea = fetch_word() + {8'h00, cpu_x};
            OPC_LDA_ABY, OPC_LDX_ABY, OPC_STA_ABY:
                ea = fetch_word() + {8'h00, cpu_y};
            OPC_LDA_IZX, OPC_STA_IZX:
                ea = zp_ptr(fetch_byte() + cpu_x);
            OPC_LDA_IZY, OPC_STA_IZY:
                ea = zp_ptr(fetch_byte()) + {8'h00, cpu_y};
            default: return 1;
        endcase
        case (opc)
            OPC_LDA_ZP, OPC_LDA_ZPX, OPC_LDA_ABS, OPC_LDA_ABX, OPC_LDA_ABY,
            OPC_LDA_IZX, OPC_LDA_IZY:
            begin cpu_a = mem_rd(ea); upd_nz(cpu_a); end
            OPC_LDX_ZP, OPC_LDX_ZPY, OPC_LDX_ABS, OPC_LDX_ABY:
            begin cpu_x = mem_rd(ea); upd_nz(cpu_x); end
            OPC_LDY_ZP, OPC_LDY_ZPX, OPC_LDY_ABS, OPC_LDY_ABX:
            begin cpu_y = mem_rd(ea); upd_nz(cpu_y); end
            OPC_STX_ZP, OPC_STX_ZPY, OPC_STX_ABS:
                cpu_mem[ea % MEM_DEPTH] = cpu_x;
            OPC_STY_ZP, OPC_STY_ZPX, OPC_STY_ABS:
                cpu_mem[ea % MEM_DEPTH] = cpu_y;
            default:
                cpu_mem[ea % MEM_DEPTH] = cpu_a;
        endcase
        return 0;
    endfunction

    // Apply one beat to the predictor and return the register set it leaves
    function automatic cpu_state_t predict_step(input op_t op, input logic [15:0] addr,
                                                input logic [7:0] data);
        cpu_state_t r;
        r = '0;
        case (op)
            OP_WRITE: cpu_mem[addr % MEM_DEPTH] = data;
            OP_READ:  r.read_data = mem_rd(addr);
            OP_EXEC:  r.status = exec_insn();
            default:  ;
        endcase
        r.prog_counter  = cpu_pc;
        r.accumulator   = cpu_a;
        r.index_x       = cpu_x;
        r.index_y       = cpu_y;
        r.stack_pointer = cpu_sp;
        r.status_flags  = cpu_p;
        return r;
    endfunction

    // Send one beat, holding it until the core takes it
    task automatic send_beat(input op_t op, input logic [15:0] addr, input logic [7:0] data,
                             input bit has_exp, input cpu_state_t exp);
        while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, data, addr, op};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        s_axis_tvalid <= 1'b0;
        pending_results.push_back(predict_step(op, addr, data));
        directed_checks.push_back(exp);
        directed_has.push_back(has_exp);
        // Core is busy after taking a beat
        @(posedge clk);
    endtask

    task automatic send_plain(input op_t op, input logic [15:0] addr, input logic [7:0] data);
        send_beat(op, addr, data, 1'b0, '0);
    endtask

    // Place a small program at a random address and jump to it
    task automatic run_program(input logic [7:0] code[]);
        logic [15:0] base;
        logic [15:0] at;
        int          k;
        base = $urandom_range(2) == 0 ? 16'hFFFE : 16'($urandom_range(16'hFFFF, 16'h0200));
        for (k = 0; k < code.size(); k++) send_plain(OP_WRITE, base + k[15:0], code[k]);
        // Put a JMP to base at PC and take it
        at = cpu_pc;
        send_plain(OP_WRITE, at, OPC_JMP_ABS);
        send_plain(OP_WRITE, at + 16'd1, base[7:0]);
        send_plain(OP_WRITE, at + 16'd2, base[15:8]);
        send_plain(OP_EXEC, 16'd0, 8'd0);
    endtask

    function automatic logic [7:0] rand_opcode();
        logic [7:0] known[] = '{OPC_LDA_IMM, OPC_LDX_IMM, OPC_LDY_IMM, OPC_ADC_IMM,
            OPC_SBC_IMM, OPC_JMP_ABS, OPC_JMP_IND, OPC_JSR, OPC_RTS, OPC_CLC, OPC_SEC,
            OPC_CLI, OPC_SEI, OPC_CLV, OPC_CLD, OPC_SED, OPC_LDA_ZP, OPC_LDX_ZP,
            OPC_LDY_ZP, OPC_STA_ZP, OPC_STX_ZP, OPC_STY_ZP, OPC_LDA_ZPX, OPC_LDY_ZPX,
            OPC_STA_ZPX, OPC_STY_ZPX, OPC_LDX_ZPY, OPC_STX_ZPY, OPC_LDA_ABS, OPC_LDX_ABS,
            OPC_LDY_ABS, OPC_STA_ABS, OPC_STX_ABS, OPC_STY_ABS, OPC_LDA_ABX, OPC_LDY_ABX,
            OPC_STA_ABX, OPC_LDA_ABY, OPC_LDX_ABY, OPC_STA_ABY, OPC_LDA_IZX, OPC_STA_IZX,
            OPC_LDA_IZY, OPC_STA_IZY};
        if ($urandom_range(19) == 0) return 8'($urandom_range(255));
        return known[$urandom_range(known.size() - 1)];
    endfunction

    // Receiver: stall at random and check each result beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                cpu_state_t got;
                cpu_state_t want;
                got = m_axis_tdata[64:0];
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected beat", 32'd0, 32'd0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (directed_has.pop_front())
                        want = directed_checks.pop_front();
                    else
                        void'(directed_checks.pop_front());
                    if (got.status != want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.read_data != want.read_data)
                        report_mismatch("read_data", 32'(got.read_data),
                                        32'(want.read_data));
                    if (got.prog_counter != want.prog_counter)
                        report_mismatch("prog_counter", 32'(got.prog_counter),
                                        32'(want.prog_counter));
                    if (got.accumulator != want.accumulator)
                        report_mismatch("accumulator", 32'(got.accumulator),
                                        32'(want.accumulator));
                    if (got.index_x != want.index_x)
                        report_mismatch("index_x", 32'(got.index_x), 32'(want.index_x));
                    if (got.index_y != want.index_y)
                        report_mismatch("index_y", 32'(got.index_y), 32'(want.index_y));
                    if (got.stack_pointer != want.stack_pointer)
                        report_mismatch("stack_pointer", 32'(got.stack_pointer),
                                        32'(want.stack_pointer));
                    if (got.status_flags != want.status_flags)
                        report_mismatch("status_flags", 32'(got.status_flags),
                                        32'(want.status_flags));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles with no beat taken on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT + MEM_DEPTH)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        stim_row_t   rows[$];
        stim_row_t   row;
        cpu_state_t  exp;
        logic [7:0]  prog[];
        int          i;
        int          phase;
        int          wait_cnt;

        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (cpu_mem[j]) cpu_mem[j] = 8'd0;
        cpu_pc = PC_RESET;
        cpu_a  = 8'd0;
        cpu_x  = 8'd0;
        cpu_y  = 8'd0;
        cpu_sp = SP_RESET;
        cpu_p  = 8'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table: expected values typed in where obvious
        exp = '0;
        exp.prog_counter = PC_RESET;
        exp.stack_pointer = SP_RESET;
        rows.push_back('{OP_READ, 16'h0000, 8'h00, 1'b1, exp});
        rows.push_back('{OP_NONE, 16'hFFFF, 8'hFF, 1'b1, exp});
        rows.push_back('{OP_WRITE, 16'hFFFF, 8'hFF, 1'b1, exp});
        exp.read_data = 8'hFF;
        rows.push_back('{OP_READ, 16'hFFFF, 8'h00, 1'b1, exp});
        rows.push_back('{OP_WRITE, 16'hFFFC, OPC_ILLEGAL, 1'b0, '0});
        exp.read_data = 8'h00;
        exp.status = 1'b1;
        exp.prog_counter = 16'hFFFD;
        rows.push_back('{OP_EXEC, 16'h0000, 8'h00, 1'b1, exp});
        // SED at FFFD, LDA #$80 at FFFE..FFFF, then SBC with wrap of PC, JSR and RTS
        rows.push_back('{OP_WRITE, 16'hFFFD, OPC_SED, 1'b0, '0});
        rows.push_back('{OP_EXEC, 16'h0000, 8'h00, 1'b0, '0});
        rows.push_back('{OP_WRITE, 16'hFFFE, OPC_LDA_IMM, 1'b0, '0});
        rows.push_back('{OP_WRITE, 16'hFFFF, 8'h80, 1'b0, '0});
        rows.push_back('{OP_EXEC, 16'h0000, 8'h00, 1'b0, '0});
        rows.push_back('{OP_WRITE, 16'h0000, OPC_SBC_IMM, 1'b0, '0});
        rows.push_back('{OP_WRITE, 16'h0001, 8'h01, 1'b0, '0});
        rows.push_back('{OP_EXEC, 16'h0000, 8'h00, 1'b0, '0});
        rows.push_back('{OP_WRITE, 16'h0002, OPC_JSR, 1'b0, '0});
        rows.push_back('{OP_WRITE, 16'h0003, 8'h40, 1'b0, '0});
        rows.push_back('{OP_WRITE, 16'h0004, 8'h00, 1'b0, '0});
        rows.push_back('{OP_EXEC, 16'h0000, 8'h00, 1'b0, '0});
        rows.push_back('{OP_WRITE, 16'h0040, OPC_RTS, 1'b0, '0});
        rows.push_back('{OP_EXEC, 16'h0000, 8'h00, 1'b0, '0});
        rows.push_back('{OP_READ, 16'h01FF, 8'h00, 1'b0, '0});
        rows.push_back('{OP_READ, 16'h01FE, 8'h00, 1'b0, '0});
        foreach (rows[r])
        begin
            row = rows[r];
            send_beat(row.op, row.addr, row.data, row.has_exp, row.exp);
        end

        // Random part in idling phases
        for (i = 0; i < N_RANDOM; i++)
        begin
            phase = (i * 5) / N_RANDOM;
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                3: begin send_idle_pct = 17; recv_stall_pct = 17; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            // Hold off once until the core has drained
            if (i == N_RANDOM / 2)
                while (pending_results.size() != 0) @(posedge clk);
            case ($urandom_range(9))
                0: send_plain(op_t'($urandom_range(3)), 16'($urandom_range(16'hFFFF)),
                              8'($urandom_range(255)));
                1: send_plain(OP_READ, {8'h01, 8'($urandom_range(255))}, 8'd0);
                2: send_plain(OP_WRITE, 16'($urandom_range(255)), 8'($urandom_range(255)));
                3:
                begin
                    // Plant a short program, jump to it and run its first instruction
                    prog = new[3];
                    prog[0] = rand_opcode();
                    prog[1] = 8'($urandom_range(255));
                    prog[2] = $urandom_range(3) == 0 ? 8'h01 : 8'($urandom_range(255));
                    run_program(prog);
                    send_plain(OP_EXEC, 16'd0, 8'd0);
                    i += 7;
                end
                default:
                begin
                    // Write an instruction at PC and execute it
                    send_plain(OP_WRITE, cpu_pc, rand_opcode());
                    send_plain(OP_WRITE, cpu_pc + 16'd1, 8'($urandom_range(255)));
                    send_plain(OP_WRITE, cpu_pc + 16'd2,
                               $urandom_range(1) ? 8'h00 : 8'($urandom_range(255)));
                    send_plain(OP_EXEC, 16'($urandom_range(16'hFFFF)),
                               8'($urandom_range(255)));
                    i += 3;
                end
            endcase
        end
        recv_stall_pct = 0;

        // Drain, then let the core settle
        wait_cnt = 0;
        while (pending_results.size() != 0 && wait_cnt < 100000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
